@@ sv/bal_pkg.sv @@
// bal_pkg: shared types and constants for the bounded array list engine
// no dependencies

package bal_pkg;

    localparam int unsigned DEPTH      = 256;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        FN_APPEND   = 3'd0,
        FN_INSERT   = 3'd1,
        FN_DEL_VAL  = 3'd2,
        FN_DEL_AT   = 3'd3,
        FN_LSEARCH  = 3'd4,
        FN_BSEARCH  = 3'd5,
        FN_SORT     = 3'd6,
        FN_NONE     = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,        // issue read for the step named by ret
        S_CAP,       // delete at index: capture the removed entry
        S_LIN,       // linear compare
        S_BIN,       // binary compare
        S_SHR,       // shift right step write
        S_SHL,       // shift left step write
        S_SRT_KEY,   // sort: key read back
        S_SRT_CMP,   // sort: compare entry i-1 with key
        S_DONE
    } state_t;

endpackage

@@ sv/bounded_array_list_engine_core.sv @@
// bounded_array_list_engine_core: list store with a single-port sequencer
// depends on bal_pkg
//
// busy covers the whole transaction (strobe on the cycle after it); append, errors
//   and no-op go straight to the done state; insert, delete, search and sort walk
//   the store through the read state
// a new start is taken only when idle; the next start is taken during the strobe
// each store step reads, then uses the data read; the receiver cannot stall
// reset: count and state cleared, store contents left undefined, no clearing pass

module bounded_array_list_engine_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               func,
    input  logic [7:0]               position,
    input  logic signed [31:0]       value,
    output logic                     done,
    output logic [2:0]               status,
    output logic [7:0]               found_position,
    output logic signed [31:0]       removed_value,
    output logic [8:0]               occupancy
);

    localparam int unsigned AW = bal_pkg::ADDR_W;
    localparam int unsigned CW = bal_pkg::CNT_W;
    localparam int unsigned DW = bal_pkg::DATA_WIDTH;

    // entry store, one write and one registered read per cycle
    logic signed [DW-1:0] mem [bal_pkg::DEPTH];
    logic signed [DW-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    bal_pkg::state_t state_reg, state_next;
    bal_pkg::func_t  func_reg, func_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [7:0]           pos_reg, pos_next;
    logic signed [DW-1:0] val_reg, val_next;
    logic signed [DW-1:0] key_reg, key_next;
    // i: walk index; j: outer sort index; lo/hi: binary range (signed-safe, CW+1)
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    logic signed [CW:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]        mid;
    bal_pkg::state_t      ret_reg, ret_next;
    logic [2:0]           st_reg, st_next;
    logic [7:0]           fpos_reg, fpos_next;
    logic signed [31:0]   rem_reg, rem_next;
    logic                 done_reg, done_next;

    // shared compare unit
    logic signed [DW-1:0] cmp_a;
    logic                 cmp_eq, cmp_lt;
    assign cmp_a  = (state_reg == bal_pkg::S_SRT_CMP) ? key_reg : val_reg;
    assign cmp_eq = (cmp_a == rd_data_reg);
    assign cmp_lt = (cmp_a < rd_data_reg);

    logic signed [CW:0] mid_w;
    assign mid_w = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign mid   = mid_w[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bal_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        key_reg  <= key_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        ret_reg  <= ret_next;
        st_reg   <= st_next;
        fpos_reg <= fpos_next;
        rem_reg  <= rem_next;
    end

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        key_next   = key_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        ret_next   = ret_reg;
        st_next    = st_reg;
        fpos_next  = fpos_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        rd_addr    = i_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = i_reg[AW-1:0];
        wr_data    = rd_data_reg;

        case (state_reg)
            bal_pkg::S_IDLE:
            begin
                if (start)
                begin
                    func_next = bal_pkg::func_t'(func);
                    pos_next  = position;
                    val_next  = value;
                    st_next   = bal_pkg::ST_OK;
                    fpos_next = '0;
                    rem_next  = '0;
                    state_next = bal_pkg::S_DONE;
                    case (bal_pkg::func_t'(func))
                        bal_pkg::FN_APPEND:
                        begin
                            if (count_reg >= CW'(bal_pkg::DEPTH))
                                st_next = bal_pkg::ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bal_pkg::FN_INSERT:
                        begin
                            if (CW'(position) >= count_reg)
                                st_next = bal_pkg::ST_BAD_INDEX;
                            else if (count_reg >= CW'(bal_pkg::DEPTH))
                                st_next = bal_pkg::ST_FULL;
                            else
                            begin
                                // move from the top down: i is the destination
                                i_next     = count_reg;
                                ret_next   = bal_pkg::S_SHR;
                                state_next = bal_pkg::S_RD;
                            end
                        end
                        bal_pkg::FN_DEL_VAL, bal_pkg::FN_LSEARCH:
                        begin
                            i_next = '0;
                            if (count_reg == '0)
                                st_next = bal_pkg::ST_NOT_FOUND;
                            else
                                state_next = bal_pkg::S_RD;
                            ret_next = bal_pkg::S_LIN;
                        end
                        bal_pkg::FN_DEL_AT:
                        begin
                            if (count_reg == '0)
                                st_next = bal_pkg::ST_EMPTY;
                            else if (CW'(position) >= count_reg)
                                st_next = bal_pkg::ST_BAD_INDEX;
                            else
                            begin
                                // read the entry at pos first, then close the gap
                                i_next     = CW'(position);
                                ret_next   = bal_pkg::S_CAP;
                                state_next = bal_pkg::S_RD;
                            end
                        end
                        bal_pkg::FN_BSEARCH:
                        begin
                            lo_next = '0;
                            hi_next = (CW+1)'($signed({1'b0, count_reg}) - 1);
                            if (count_reg == '0)
                                st_next = bal_pkg::ST_NOT_FOUND;
                            else
                            begin
                                ret_next   = bal_pkg::S_BIN;
                                state_next = bal_pkg::S_RD;
                            end
                        end
                        bal_pkg::FN_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                j_next     = CW'(1);
                                i_next     = CW'(1);
                                ret_next   = bal_pkg::S_SRT_KEY;
                                state_next = bal_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            bal_pkg::S_RD:
            begin
                // shift, sort and binary loop ends are checked here, data comes back in the ret state
                case (ret_reg)
                    bal_pkg::S_SHR:
                    begin
                        if (i_reg == CW'(pos_reg))
                        begin
                            // gap is open at pos, drop the new entry in
                            wr_en      = 1'b1;
                            wr_data    = val_reg;
                            count_next = count_reg + 1'b1;
                            state_next = bal_pkg::S_DONE;
                        end
                        else
                        begin
                            rd_addr    = AW'(i_reg - 1'b1);
                            state_next = bal_pkg::S_SHR;
                        end
                    end
                    bal_pkg::S_SHL:
                    begin
                        if (i_reg + 1'b1 >= count_reg)
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = bal_pkg::S_DONE;
                        end
                        else
                        begin
                            rd_addr    = AW'(i_reg + 1'b1);
                            state_next = bal_pkg::S_SHL;
                        end
                    end
                    bal_pkg::S_SRT_CMP:
                    begin
                        if (i_reg == '0)
                        begin
                            // key reached the head
                            wr_en   = 1'b1;
                            wr_data = key_reg;
                            if (j_reg + 1'b1 >= count_reg)
                                state_next = bal_pkg::S_DONE;
                            else
                            begin
                                j_next     = j_reg + 1'b1;
                                i_next     = j_reg + 1'b1;
                                ret_next   = bal_pkg::S_SRT_KEY;
                                state_next = bal_pkg::S_RD;
                            end
                        end
                        else
                        begin
                            rd_addr    = AW'(i_reg - 1'b1);
                            state_next = bal_pkg::S_SRT_CMP;
                        end
                    end
                    bal_pkg::S_BIN:
                    begin
                        if (lo_reg > hi_reg)
                        begin
                            st_next    = bal_pkg::ST_NOT_FOUND;
                            state_next = bal_pkg::S_DONE;
                        end
                        else
                        begin
                            i_next     = mid;
                            rd_addr    = mid_w[AW-1:0];
                            state_next = bal_pkg::S_BIN;
                        end
                    end
                    default:
                    begin
                        rd_addr    = i_reg[AW-1:0];
                        state_next = ret_reg;
                    end
                endcase
            end

            bal_pkg::S_CAP:
            begin
                rem_next   = 32'(rd_data_reg);
                ret_next   = bal_pkg::S_SHL;
                state_next = bal_pkg::S_RD;
            end

            bal_pkg::S_LIN:
            begin
                if (cmp_eq)
                begin
                    fpos_next = i_reg[7:0];
                    if (func_reg == bal_pkg::FN_DEL_VAL)
                    begin
                        rem_next   = 32'(rd_data_reg);
                        ret_next   = bal_pkg::S_SHL;
                        state_next = bal_pkg::S_RD;
                    end
                    else
                        state_next = bal_pkg::S_DONE;
                end
                else if (i_reg + 1'b1 >= count_reg)
                begin
                    st_next    = bal_pkg::ST_NOT_FOUND;
                    state_next = bal_pkg::S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = bal_pkg::S_RD;
                end
            end

            bal_pkg::S_BIN:
            begin
                if (cmp_eq)
                begin
                    fpos_next  = i_reg[7:0];
                    state_next = bal_pkg::S_DONE;
                end
                else
                begin
                    // halve the range even when the list is not sorted
                    if (cmp_lt)
                        hi_next = (CW+1)'($signed({1'b0, i_reg}) - 1);
                    else
                        lo_next = (CW+1)'($signed({1'b0, i_reg}) + 1);
                    state_next = bal_pkg::S_RD;
                end
            end

            bal_pkg::S_SHR:
            begin
                // store[i] = store[i-1]
                wr_en      = 1'b1;
                i_next     = i_reg - 1'b1;
                state_next = bal_pkg::S_RD;
            end

            bal_pkg::S_SHL:
            begin
                // store[i] = store[i+1]
                wr_en      = 1'b1;
                i_next     = i_reg + 1'b1;
                state_next = bal_pkg::S_RD;
            end

            bal_pkg::S_SRT_KEY:
            begin
                key_next   = rd_data_reg;
                ret_next   = bal_pkg::S_SRT_CMP;
                state_next = bal_pkg::S_RD;
            end

            bal_pkg::S_SRT_CMP:
            begin
                // rd_data is store[i-1]; key below it means move it up
                wr_en = 1'b1;
                if (cmp_lt)
                begin
                    i_next     = i_reg - 1'b1;
                    state_next = bal_pkg::S_RD;
                end
                else
                begin
                    // place key at i, advance outer index
                    wr_data = key_reg;
                    if (j_reg + 1'b1 >= count_reg)
                        state_next = bal_pkg::S_DONE;
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        i_next     = j_reg + 1'b1;
                        ret_next   = bal_pkg::S_SRT_KEY;
                        state_next = bal_pkg::S_RD;
                    end
                end
            end

            bal_pkg::S_DONE:
            begin
                done_next  = 1'b1;
                state_next = bal_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bal_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != bal_pkg::S_IDLE);
    assign done           = done_reg;
    assign status         = st_reg;
    assign found_position = fpos_reg;
    assign removed_value  = rem_reg;
    assign occupancy      = 9'(count_reg);

endmodule

@@ sv/bal_checker.sv @@
// bal_checker: port-level checks on bounded_array_list_engine_core
// depends on bal_pkg; bound to the top level below

module bal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic [8:0]  occupancy
);

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= 9'(bal_pkg::DEPTH))
        else $error("occupancy beyond depth");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction not taken");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= 3'(bal_pkg::ST_NOT_FOUND)))
        else $error("status code out of range");

    a_occ_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start && !done) |=> $stable(occupancy))
        else $error("occupancy changed while idle");

endmodule

bind bounded_array_list_engine_core bal_checker u_bal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .occupancy (occupancy)
);
